### src/pickle_frame_encoder_macros.svh
// Assertion macros for the pickle frame encoder.
`ifndef PICKLE_FRAME_ENCODER_MACROS_SVH
`define PICKLE_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define PFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset only.
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pfe_pkg.sv
package pfe_pkg;

	// Item kinds
	localparam logic [2:0] KIND_BOOL   = 3'd0;
	localparam logic [2:0] KIND_INT    = 3'd1;
	localparam logic [2:0] KIND_DOUBLE = 3'd2;
	localparam logic [2:0] KIND_HEADER = 3'd3;
	localparam logic [2:0] KIND_CHAR   = 3'd4;
	localparam logic [2:0] KIND_END    = 3'd5;

	// Pickle opcodes
	localparam logic [7:0] OP_NEWTRUE   = 8'h88;
	localparam logic [7:0] OP_NEWFALSE  = 8'h89;
	localparam logic [7:0] OP_BININT1   = 8'h4b;
	localparam logic [7:0] OP_BININT2   = 8'h4d;
	localparam logic [7:0] OP_BININT    = 8'h4a;
	localparam logic [7:0] OP_BINFLOAT  = 8'h47;
	localparam logic [7:0] OP_SHORT_UNI = 8'h8c;
	localparam logic [7:0] OP_UNI       = 8'h58;
	localparam logic [7:0] OP_BINPUT    = 8'h71;
	localparam logic [7:0] OP_TUPLE1    = 8'h85;
	localparam logic [7:0] OP_TUPLE2    = 8'h86;
	localparam logic [7:0] OP_TUPLE3    = 8'h87;
	localparam logic [7:0] OP_TUPLE     = 8'h74;

	// Memo slots and terminator
	localparam logic [7:0] MEMO_STRING = 8'h00;
	localparam logic [7:0] MEMO_TUPLE  = 8'h01;
	localparam logic [7:0] BYTE_STOP   = 8'h00;

	// Element count saturates here
	localparam logic [2:0] EC_MAX = 3'd7;

	// Longest byte run of one item (a double)
	localparam int MAX_BYTES = 9;
	localparam int NB_W      = $clog2(MAX_BYTES + 1);
	localparam int IDX_W     = $clog2(MAX_BYTES);

	// Queue between front and back; depth is a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [2:0]         kind;
		logic               flag;
		logic signed [31:0] int_value;
		logic [63:0]        double_bits;
		logic [15:0]        text_length;
		logic [7:0]         char_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       frame_end;
	} out_item_t;

	// One classified item: bytes[0] goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [NB_W-1:0]           nbytes;
		logic                      frame_end;
	} job_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### src/pfe_front.sv
module pfe_front
	import pfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	input  q_status_t q_stat,
	output logic      push,
	output job_t      push_job
);

	logic [2:0]  ec_q;
	logic [15:0] cl_q;
	logic [2:0]  ec_d;
	logic [15:0] cl_d;
	logic [2:0]  ec_inc;
	logic        accept;
	job_t        job;

	assign item_stall = q_stat.full;
	assign accept     = item_valid && !item_stall;
	assign ec_inc     = (ec_q != EC_MAX) ? ec_q + 3'd1 : ec_q;

	// Classify the item into its byte run and next state
	always_comb begin
		job   = '0;
		ec_d  = ec_q;
		cl_d  = cl_q;
		case (item.kind)
			KIND_BOOL: begin
				ec_d          = ec_inc;
				job.bytes[0]  = item.flag ? OP_NEWTRUE : OP_NEWFALSE;
				job.nbytes    = NB_W'(1);
			end
			KIND_INT: begin
				ec_d = ec_inc;
				if ($unsigned(item.int_value) <= 32'h0000_00ff) begin
					job.bytes[0] = OP_BININT1;
					job.bytes[1] = item.int_value[7:0];
					job.nbytes   = NB_W'(2);
				end else if ($unsigned(item.int_value) <= 32'h0000_ffff) begin
					job.bytes[0] = OP_BININT2;
					job.bytes[1] = item.int_value[7:0];
					job.bytes[2] = item.int_value[15:8];
					job.nbytes   = NB_W'(3);
				end else begin
					job.bytes[0] = OP_BININT;
					job.bytes[1] = item.int_value[7:0];
					job.bytes[2] = item.int_value[15:8];
					job.bytes[3] = item.int_value[23:16];
					job.bytes[4] = item.int_value[31:24];
					job.nbytes   = NB_W'(5);
				end
			end
			KIND_DOUBLE: begin
				ec_d         = ec_inc;
				job.bytes[0] = OP_BINFLOAT;
				// most significant byte first
				for (int i = 0; i < 8; i++) begin
					job.bytes[i+1] = item.double_bits[8*(7-i) +: 8];
				end
				job.nbytes = NB_W'(9);
			end
			KIND_HEADER: begin
				ec_d = ec_inc;
				cl_d = item.text_length;
				if (item.text_length <= 16'h00ff) begin
					job.bytes[0] = OP_SHORT_UNI;
					job.bytes[1] = item.text_length[7:0];
					if (item.text_length == 16'h0000) begin
						// empty string: memo it at once
						job.bytes[2] = OP_BINPUT;
						job.bytes[3] = MEMO_STRING;
						job.nbytes   = NB_W'(4);
					end else begin
						job.nbytes = NB_W'(2);
					end
				end else begin
					job.bytes[0] = OP_UNI;
					job.bytes[1] = item.text_length[7:0];
					job.bytes[2] = item.text_length[15:8];
					job.bytes[3] = 8'h00;
					job.bytes[4] = 8'h00;
					job.nbytes   = NB_W'(5);
				end
			end
			KIND_CHAR: begin
				// stray characters are dropped
				if (cl_q != 16'h0000) begin
					cl_d         = cl_q - 16'd1;
					job.bytes[0] = item.char_byte;
					if (cl_q == 16'h0001) begin
						job.bytes[1] = OP_BINPUT;
						job.bytes[2] = MEMO_STRING;
						job.nbytes   = NB_W'(3);
					end else begin
						job.nbytes = NB_W'(1);
					end
				end
			end
			KIND_END: begin
				ec_d          = 3'd0;
				cl_d          = 16'h0000;
				job.frame_end = 1'b1;
				if (ec_q != 3'd0) begin
					case (ec_q)
						3'd1:    job.bytes[0] = OP_TUPLE1;
						3'd2:    job.bytes[0] = OP_TUPLE2;
						3'd3:    job.bytes[0] = OP_TUPLE3;
						default: job.bytes[0] = OP_TUPLE;
					endcase
					job.bytes[1] = OP_BINPUT;
					job.bytes[2] = MEMO_TUPLE;
					job.bytes[3] = BYTE_STOP;
					job.nbytes   = NB_W'(4);
				end else begin
					job.bytes[0] = BYTE_STOP;
					job.nbytes   = NB_W'(1);
				end
			end
			default: begin
				// unused kinds: no bytes, no state change
			end
		endcase
	end

	assign push     = accept && (job.nbytes != '0);
	assign push_job = job;

	// Frame and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q <= 3'd0;
			cl_q <= 16'h0000;
		end else if (accept) begin
			ec_q <= ec_d;
			cl_q <= cl_d;
		end
	end

endmodule

### src/pfe_queue.sv
module pfe_queue
	import pfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t stat
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### src/pfe_back.sv
module pfe_back
	import pfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  q_status_t q_stat,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             load;
	logic             last;

	assign load      = !q_stat.empty && (!out_valid_q || !res_stall);
	assign last      = (NB_W'(idx_q) == head.nbytes - NB_W'(1));
	assign pop       = load && last;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// Byte walker and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last ? '0 : idx_q + 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte    <= head.bytes[idx_q];
			out_q.last_of_run <= last;
			out_q.frame_end   <= last && head.frame_end;
		end
	end

endmodule

### src/pickle_frame_encoder.sv
// With the queue and output register idle, an item's first byte is written to the job queue
// and then to the output register before it is offered. Throughput: one byte per cycle at
// the output while res_stall is low; an item of n bytes (1 to 9, a double nine) holds the
// output until all n are sent. A two-entry job queue lets the input take a new item every cycle while it has room.
// Reset: arst_n clears element count, pending characters, queue and output valid.
`include "pickle_frame_encoder_macros.svh"

module pickle_frame_encoder
	import pfe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	q_status_t q_stat;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      head;

	pfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.push_job   (push_job)
	);

	pfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	pfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Checks
	`PFE_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !q_stat.full, "push into full queue")
	`PFE_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")
	`PFE_ASSERT_NOW(a_stop_byte, clk, arst_n, res_valid && res.frame_end, res.last_of_run && res.out_byte == BYTE_STOP, "frame end not on final zero byte")
	`PFE_ASSERT_NEXT(a_fill_after_push, clk, arst_n, push && !pop, !q_stat.empty, "queue empty after push")

endmodule
